// ===== rtl/hrhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared codes and the per-beat result type of the request head lexer.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_URI     = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_NAME    = 3'd3;
	localparam logic [2:0] KIND_VALUE   = 3'd4;
	localparam logic [2:0] KIND_BODY    = 3'd5;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_LINE_END     = 3'd1;
	localparam logic [2:0] ERR_EXTRA_ELEM   = 3'd2;
	localparam logic [2:0] ERR_BAD_VERSION  = 3'd3;
	localparam logic [2:0] ERR_BAD_NAME     = 3'd4;
	localparam logic [2:0] ERR_HEADER_END   = 3'd5;
	localparam logic [2:0] ERR_HEAD_END     = 3'd6;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [2:0] out_kind;
		logic       token_end;
		logic       head_done;
		logic [2:0] error_code;
	} result_t;

endpackage

// ===== rtl/hrhp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser channels
// Valid/ready channels for input bytes and lexer results.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       msg_start;

	modport source (output valid, output in_byte, output msg_start, input ready);
	modport sink (input valid, input in_byte, input msg_start, output ready);
endinterface

interface hrhp_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [2:0] out_kind;
	logic       token_end;
	logic       head_done;
	logic [2:0] error_code;

	modport source (output valid, output out_valid, output out_byte, output out_kind,
		output token_end, output head_done, output error_code, input ready);
	modport sink (input valid, input out_valid, input out_byte, input out_kind,
		input token_end, input head_done, input error_code, output ready);
endinterface

// ===== rtl/hrhp_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head lexer
// Holds the parse state and computes the result of one byte per beat.
// ----------------------------------------------------------------------------
module hrhp_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                msg_start,
	output hrhp_pkg::result_t   res
);

	typedef enum logic [3:0] {
		PH_METHOD, PH_URI, PH_VERSION, PH_VER_LF, PH_EXTRA, PH_NAME_START,
		PH_NAME, PH_COLON, PH_VALUE, PH_HDR_LF, PH_HEAD_CR, PH_BODY, PH_ERROR
	} phase_t;

	phase_t     phase_q, ph, ph_n;
	logic [2:0] pm_q, pm, pm_n;
	logic       ws_q, ws, ws_n;
	logic [2:0] err_q, se, se_n;
	logic       fail;
	logic [2:0] fcode;
	logic       nm_ok;
	logic [7:0] nm_c;

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return (b inside {["a":"z"]}) ? b - 8'd32 : b;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b inside {["A":"Z"]}) ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] ver_char(input logic [2:0] i);
		case (i)
			3'd0: return "H";
			3'd1: return "T";
			3'd2: return "T";
			3'd3: return "P";
			3'd4: return "/";
			default: return 8'h00;
		endcase
	endfunction

	always_comb begin
		ph = msg_start ? PH_METHOD : phase_q;
		pm = msg_start ? 3'd0 : pm_q;
		ws = msg_start ? 1'b1 : ws_q;
		se = msg_start ? hrhp_pkg::ERR_NONE : err_q;
		ph_n = ph;
		pm_n = pm;
		ws_n = ws;
		se_n = se;
		fail = 1'b0;
		fcode = hrhp_pkg::ERR_NONE;
		res = '0;
		nm_ok = (in_byte inside {["a":"z"], ["A":"Z"], ["0":"9"]}) ||
			in_byte == hrhp_pkg::CH_DASH || in_byte == hrhp_pkg::CH_UNDER;
		nm_c = ws ? to_upper(in_byte) : to_lower(in_byte);
		case (ph)
			PH_METHOD, PH_URI: begin
				if (in_byte == hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = (pm != 3'd0) ? hrhp_pkg::ERR_BAD_VERSION : hrhp_pkg::ERR_LINE_END;
				end else if (in_byte == hrhp_pkg::CH_SP) begin
					res.token_end = 1'b1;
					res.out_kind = (ph == PH_METHOD) ? hrhp_pkg::KIND_METHOD : hrhp_pkg::KIND_URI;
					ph_n = (ph == PH_METHOD) ? PH_URI : PH_VERSION;
					pm_n = 3'd0;
				end else begin
					pm_n = (in_byte == hrhp_pkg::CH_CR) ? 3'd1 : 3'd0;
					res.out_valid = 1'b1;
					res.out_byte = (ph == PH_METHOD) ? to_upper(in_byte) : in_byte;
					res.out_kind = (ph == PH_METHOD) ? hrhp_pkg::KIND_METHOD : hrhp_pkg::KIND_URI;
				end
			end
			PH_VERSION: begin
				if (in_byte == hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_LINE_END;
				end else if (in_byte == hrhp_pkg::CH_SP) begin
					ph_n = PH_EXTRA;
					pm_n = 3'd0;
				end else if (in_byte == hrhp_pkg::CH_CR) begin
					ph_n = PH_VER_LF;
					res.out_kind = hrhp_pkg::KIND_VERSION;
					res.token_end = 1'b1;
				end else begin
					if (pm < 3'd5) begin
						pm_n = (in_byte == ver_char(pm)) ? pm + 3'd1 : 3'd7;
					end
					res.out_valid = 1'b1;
					res.out_byte = in_byte;
					res.out_kind = hrhp_pkg::KIND_VERSION;
				end
			end
			PH_VER_LF: begin
				if (in_byte != hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_LINE_END;
				end else if (pm != 3'd5) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_BAD_VERSION;
				end else begin
					ph_n = PH_NAME_START;
					ws_n = 1'b1;
				end
			end
			PH_EXTRA: begin
				if (in_byte == hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = (pm != 3'd0) ? hrhp_pkg::ERR_EXTRA_ELEM : hrhp_pkg::ERR_LINE_END;
				end else begin
					pm_n = (in_byte == hrhp_pkg::CH_CR) ? 3'd1 : 3'd0;
				end
			end
			PH_NAME_START, PH_NAME: begin
				if (ph == PH_NAME_START) begin
					ws_n = 1'b1;
					nm_c = to_upper(in_byte);
				end
				if (ph == PH_NAME_START && in_byte == hrhp_pkg::CH_CR) begin
					ph_n = PH_HEAD_CR;
				end else if (ph == PH_NAME_START && in_byte == hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_HEAD_END;
				end else if (in_byte == hrhp_pkg::CH_COLON) begin
					ph_n = PH_COLON;
					res.out_kind = hrhp_pkg::KIND_NAME;
					res.token_end = 1'b1;
				end else if (!nm_ok) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_BAD_NAME;
				end else begin
					ws_n = (in_byte == hrhp_pkg::CH_DASH);
					ph_n = PH_NAME;
					res.out_valid = 1'b1;
					res.out_byte = nm_c;
					res.out_kind = hrhp_pkg::KIND_NAME;
				end
			end
			PH_COLON, PH_VALUE: begin
				if (ph == PH_COLON && in_byte == hrhp_pkg::CH_SP) begin
					ph_n = PH_VALUE;
				end else if (in_byte == hrhp_pkg::CH_CR) begin
					ph_n = PH_HDR_LF;
					res.out_kind = hrhp_pkg::KIND_VALUE;
					res.token_end = 1'b1;
				end else if (in_byte == hrhp_pkg::CH_LF) begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_HEADER_END;
				end else begin
					ph_n = PH_VALUE;
					res.out_valid = 1'b1;
					res.out_byte = in_byte;
					res.out_kind = hrhp_pkg::KIND_VALUE;
				end
			end
			PH_HDR_LF: begin
				if (in_byte == hrhp_pkg::CH_LF) begin
					ph_n = PH_NAME_START;
					ws_n = 1'b1;
				end else begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_HEADER_END;
				end
			end
			PH_HEAD_CR: begin
				if (in_byte == hrhp_pkg::CH_LF) begin
					ph_n = PH_BODY;
					res.head_done = 1'b1;
				end else begin
					fail = 1'b1;
					fcode = hrhp_pkg::ERR_HEAD_END;
				end
			end
			PH_BODY: begin
				res.out_valid = 1'b1;
				res.out_byte = in_byte;
				res.out_kind = hrhp_pkg::KIND_BODY;
			end
			default: begin
				res.error_code = se;
			end
		endcase
		if (fail) begin
			se_n = fcode;
			ph_n = PH_ERROR;
			res = '0;
			res.error_code = fcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			pm_q <= 3'd0;
			ws_q <= 1'b1;
			err_q <= hrhp_pkg::ERR_NONE;
		end else if (step) begin
			phase_q <= ph_n;
			pm_q <= pm_n;
			ws_q <= ws_n;
			err_q <= se_n;
		end
	end

endmodule

// ===== rtl/http_request_head_parser.sv =====
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its input byte is accepted.
// Throughput: one byte per cycle; the single output register refills in the
// cycle it is drained, so the input stalls only while a held result is not taken.
// Reset: arst_n returns the lexer to the method field with no error and
// empties the output register; msg_start restarts parsing in band.
// ----------------------------------------------------------------------------
// HTTP request head parser
// Lexes a request head byte stream into tokens, header fields and body bytes.
// ----------------------------------------------------------------------------
module http_request_head_parser (
	input  logic              clk,
	input  logic              arst_n,
	hrhp_in_if.sink           in_ch,
	hrhp_out_if.source        out_ch
);

	hrhp_pkg::result_t res, res_q;
	logic              valid_q;
	logic              step;

	assign in_ch.ready = !valid_q || out_ch.ready;
	assign step = in_ch.valid && in_ch.ready;

	hrhp_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (in_ch.in_byte),
		.msg_start (in_ch.msg_start),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.out_valid  = res_q.out_valid;
	assign out_ch.out_byte   = res_q.out_byte;
	assign out_ch.out_kind   = res_q.out_kind;
	assign out_ch.token_end  = res_q.token_end;
	assign out_ch.head_done  = res_q.head_done;
	assign out_ch.error_code = res_q.error_code;

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.error_code != hrhp_pkg::ERR_NONE) |->
		(!res_q.out_valid && !res_q.token_end && !res_q.head_done))
		else $error("error beat carries token data");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res_q.out_valid) |-> (res_q.out_byte == 8'h00))
		else $error("byte set without out_valid");

	a_head_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.head_done) |->
		(!res_q.out_valid && res_q.out_kind == hrhp_pkg::KIND_METHOD))
		else $error("head_done beat carries data");

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.token_end) |->
		(!res_q.out_valid && res_q.out_kind != hrhp_pkg::KIND_BODY))
		else $error("token end beat malformed");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_q)
		else $error("accepted byte produced no result beat");

endmodule

// ===== sim/http_request_head_parser_lex_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser result check
// Watches both channels, predicts one result beat for every accepted byte
// and compares each accepted result beat, field by field, with the oldest
// predicted beat.
// ----------------------------------------------------------------------------
module http_request_head_parser_lex_check (
	input  logic clk,
	input  logic arst_n,
	hrhp_in_if   in_ch,
	hrhp_out_if  out_ch,
	output int   mismatches,
	output int   pending
);

	localparam logic [39:0] VERSION_TAG = "HTTP/";

	typedef enum logic [3:0] {
		LX_METHOD,
		LX_URI,
		LX_VERSION,
		LX_VER_LF,
		LX_EXTRA,
		LX_NAME_START,
		LX_NAME,
		LX_COLON,
		LX_VALUE,
		LX_HDR_LF,
		LX_HEAD_CR,
		LX_BODY,
		LX_ERROR
	} lex_phase_t;

	// In the request line tag_count flags a preceding CR; in the version it
	// counts matched bytes of the protocol tag, with 7 marking a mismatch.
	lex_phase_t          phase;
	logic [2:0]          tag_count;
	logic                at_word;
	logic [2:0]          held_err;
	hrhp_pkg::result_t   expected_beats[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic void restart();
		phase = LX_METHOD;
		tag_count = 3'd0;
		at_word = 1'b1;
		held_err = hrhp_pkg::ERR_NONE;
	endfunction

	function automatic hrhp_pkg::result_t make_result(input logic valid,
			input logic [7:0] data, input logic [2:0] kind, input logic tend,
			input logic done);
		hrhp_pkg::result_t r;
		r.out_valid = valid;
		r.out_byte = data;
		r.out_kind = kind;
		r.token_end = tend;
		r.head_done = done;
		r.error_code = hrhp_pkg::ERR_NONE;
		return r;
	endfunction

	function automatic hrhp_pkg::result_t raise_error(input logic [2:0] code);
		hrhp_pkg::result_t r;
		held_err = code;
		phase = LX_ERROR;
		r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_METHOD, 1'b0, 1'b0);
		r.error_code = code;
		return r;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= "a" && b <= "z") ? b - 8'd32 : b;
	endfunction

	function automatic logic [7:0] downcase(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic hrhp_pkg::result_t name_step(input logic [7:0] b);
		logic [7:0] c;
		if (!((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9")
				|| b == hrhp_pkg::CH_DASH || b == hrhp_pkg::CH_UNDER)) begin
			return raise_error(hrhp_pkg::ERR_BAD_NAME);
		end
		c = at_word ? upcase(b) : downcase(b);
		at_word = (b == hrhp_pkg::CH_DASH);
		phase = LX_NAME;
		return make_result(1'b1, c, hrhp_pkg::KIND_NAME, 1'b0, 1'b0);
	endfunction

	function automatic hrhp_pkg::result_t value_step(input logic [7:0] b);
		phase = LX_VALUE;
		if (b == hrhp_pkg::CH_CR) begin
			phase = LX_HDR_LF;
			return make_result(1'b0, 8'h00, hrhp_pkg::KIND_VALUE, 1'b1, 1'b0);
		end
		if (b == hrhp_pkg::CH_LF) begin
			return raise_error(hrhp_pkg::ERR_HEADER_END);
		end
		return make_result(1'b1, b, hrhp_pkg::KIND_VALUE, 1'b0, 1'b0);
	endfunction

	function automatic hrhp_pkg::result_t lex_step(input logic [7:0] b, input logic start);
		hrhp_pkg::result_t r;
		logic [2:0] kind;
		if (start) begin
			restart();
		end
		r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_METHOD, 1'b0, 1'b0);
		case (phase)
			LX_METHOD, LX_URI: begin
				kind = (phase == LX_METHOD) ? hrhp_pkg::KIND_METHOD : hrhp_pkg::KIND_URI;
				if (b == hrhp_pkg::CH_LF) begin
					r = raise_error(tag_count != 0 ? hrhp_pkg::ERR_BAD_VERSION :
						hrhp_pkg::ERR_LINE_END);
				end else if (b == hrhp_pkg::CH_SP) begin
					r = make_result(1'b0, 8'h00, kind, 1'b1, 1'b0);
					phase = (phase == LX_METHOD) ? LX_URI : LX_VERSION;
					tag_count = 3'd0;
				end else begin
					tag_count = {2'b00, b == hrhp_pkg::CH_CR};
					r = make_result(1'b1, (phase == LX_METHOD) ? upcase(b) : b, kind,
						1'b0, 1'b0);
				end
			end
			LX_VERSION: begin
				if (b == hrhp_pkg::CH_LF) begin
					r = raise_error(hrhp_pkg::ERR_LINE_END);
				end else if (b == hrhp_pkg::CH_SP) begin
					phase = LX_EXTRA;
					tag_count = 3'd0;
				end else if (b == hrhp_pkg::CH_CR) begin
					phase = LX_VER_LF;
					r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_VERSION, 1'b1, 1'b0);
				end else begin
					if (tag_count < 3'd5) begin
						tag_count = (b == VERSION_TAG[39 - 8 * tag_count -: 8]) ?
							tag_count + 3'd1 : 3'd7;
					end
					r = make_result(1'b1, b, hrhp_pkg::KIND_VERSION, 1'b0, 1'b0);
				end
			end
			LX_VER_LF: begin
				if (b != hrhp_pkg::CH_LF) begin
					r = raise_error(hrhp_pkg::ERR_LINE_END);
				end else if (tag_count != 3'd5) begin
					r = raise_error(hrhp_pkg::ERR_BAD_VERSION);
				end else begin
					phase = LX_NAME_START;
					at_word = 1'b1;
				end
			end
			LX_EXTRA: begin
				if (b == hrhp_pkg::CH_LF) begin
					r = raise_error(tag_count != 0 ? hrhp_pkg::ERR_EXTRA_ELEM :
						hrhp_pkg::ERR_LINE_END);
				end else begin
					tag_count = {2'b00, b == hrhp_pkg::CH_CR};
				end
			end
			LX_NAME_START: begin
				at_word = 1'b1;
				if (b == hrhp_pkg::CH_CR) begin
					phase = LX_HEAD_CR;
				end else if (b == hrhp_pkg::CH_LF) begin
					r = raise_error(hrhp_pkg::ERR_HEAD_END);
				end else if (b == hrhp_pkg::CH_COLON) begin
					phase = LX_COLON;
					r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_NAME, 1'b1, 1'b0);
				end else begin
					r = name_step(b);
				end
			end
			LX_NAME: begin
				if (b == hrhp_pkg::CH_COLON) begin
					phase = LX_COLON;
					r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_NAME, 1'b1, 1'b0);
				end else begin
					r = name_step(b);
				end
			end
			LX_COLON: begin
				if (b == hrhp_pkg::CH_SP) begin
					phase = LX_VALUE;
				end else begin
					r = value_step(b);
				end
			end
			LX_VALUE: begin
				r = value_step(b);
			end
			LX_HDR_LF: begin
				if (b == hrhp_pkg::CH_LF) begin
					phase = LX_NAME_START;
					at_word = 1'b1;
				end else begin
					r = raise_error(hrhp_pkg::ERR_HEADER_END);
				end
			end
			LX_HEAD_CR: begin
				if (b == hrhp_pkg::CH_LF) begin
					phase = LX_BODY;
					r = make_result(1'b0, 8'h00, hrhp_pkg::KIND_METHOD, 1'b0, 1'b1);
				end else begin
					r = raise_error(hrhp_pkg::ERR_HEAD_END);
				end
			end
			LX_BODY: begin
				r = make_result(1'b1, b, hrhp_pkg::KIND_BODY, 1'b0, 1'b0);
			end
			default: begin
				r.error_code = held_err;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hrhp_pkg::result_t got;
		hrhp_pkg::result_t want;
		if (!arst_n) begin
			restart();
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.out_valid = out_ch.out_valid;
				got.out_byte = out_ch.out_byte;
				got.out_kind = out_ch.out_kind;
				got.token_end = out_ch.token_end;
				got.head_done = out_ch.head_done;
				got.error_code = out_ch.error_code;
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat %h arrived with none expected", $time, got);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					compare_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
					compare_field("out_byte", want.out_byte, got.out_byte);
					compare_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
					compare_field("token_end", 8'(want.token_end), 8'(got.token_end));
					compare_field("head_done", 8'(want.head_done), 8'(got.head_done));
					compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				expected_beats.push_back(lex_step(in_ch.in_byte, in_ch.msg_start));
			end
			pending <= expected_beats.size();
		end
	end

endmodule

// ===== sim/http_request_head_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Feeds a few directed request heads and then randomized ones, some well
// formed with random content and the rest malformed or noise, with random
// idle cycles on both channels, and reports the verdict of the result check.
// ----------------------------------------------------------------------------
module http_request_head_parser_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 800;
	localparam int DRAIN_CYCLES = 4;
	localparam string NAME_SET =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";

	typedef struct {
		logic [7:0] data;
		logic       start;
	} in_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       calm = 1'b0;
	int         cycle_count = 0;
	int         mismatches;
	int         pending;
	logic [7:0] msg[$];
	in_beat_t   byte_stream[$];

	hrhp_in_if  in_ch ();
	hrhp_out_if out_ch ();

	http_request_head_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	http_request_head_parser_lex_check lex_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.mismatches(mismatches),
		.pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("http_request_head_parser test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= arst_n && (calm || $urandom_range(99) >= 6);
	end

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			msg.push_back(s[i]);
		end
	endtask

	task automatic add_line_end();
		msg.push_back(hrhp_pkg::CH_CR);
		msg.push_back(hrhp_pkg::CH_LF);
	endtask

	function automatic logic [7:0] token_char();
		case ($urandom_range(9))
			0: return hrhp_pkg::CH_CR;
			1: return 8'($urandom_range(255, 128));
			default: return 8'($urandom_range(8'h7E, 8'h21));
		endcase
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF);
		return c;
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(4))
			0: return hrhp_pkg::CH_CR;
			1: return hrhp_pkg::CH_LF;
			2: return hrhp_pkg::CH_SP;
			3: return hrhp_pkg::CH_COLON;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic build_message();
		msg.delete();
		if ($urandom_range(19) == 0) begin
			repeat ($urandom_range(8, 1)) msg.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(4)) begin
			msg.push_back($urandom_range(1) ? 8'($urandom_range("z", "a")) : token_char());
		end
		msg.push_back(hrhp_pkg::CH_SP);
		repeat ($urandom_range(5)) msg.push_back(token_char());
		msg.push_back(hrhp_pkg::CH_SP);
		case ($urandom_range(9))
			0: add_text("HTT");
			1: add_text("HTTX/1.0");
			2: repeat ($urandom_range(4)) msg.push_back(8'($urandom_range(8'h7E, 8'h21)));
			3: add_text("HTTP/1.1 x");
			default: begin
				add_text("HTTP/");
				repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(8'h7E, 8'h21)));
			end
		endcase
		add_line_end();
		repeat ($urandom_range(3)) begin
			repeat ($urandom_range(6)) msg.push_back(NAME_SET[$urandom_range(NAME_SET.len() - 1)]);
			msg.push_back(hrhp_pkg::CH_COLON);
			if ($urandom_range(1)) begin
				msg.push_back(hrhp_pkg::CH_SP);
			end
			repeat ($urandom_range(6)) msg.push_back(value_char());
			add_line_end();
		end
		add_line_end();
		repeat ($urandom_range(5)) msg.push_back(8'($urandom));
	endtask

	task automatic damage_message();
		int pos;
		pos = $urandom_range(msg.size() - 1);
		case ($urandom_range(3))
			0: msg[pos] = special_char();
			1: msg.insert(pos, special_char());
			2: begin
				msg.insert(pos, hrhp_pkg::CH_LF);
				msg.insert(pos, hrhp_pkg::CH_CR);
			end
			default: begin
				while (msg.size() > pos + 1) void'(msg.pop_back());
			end
		endcase
	endtask

	task automatic queue_message();
		in_beat_t beat;
		foreach (msg[i]) begin
			beat.data = msg[i];
			beat.start = (i == 0);
			byte_stream.push_back(beat);
		end
	endtask

	task automatic send_beat(input in_beat_t beat);
		while (!calm && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= beat.data;
		in_ch.msg_start <= beat.start;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	initial begin
		int directed_beats;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.msg_start = 1'b0;
		out_ch.ready = 1'b0;

		// Empty URI and value, underscore and dash in a name, extreme body beats.
		msg.delete();
		add_text("g  HTTP/");
		add_line_end();
		add_text("A_b-c:");
		add_line_end();
		add_line_end();
		msg.push_back(8'hFF);
		msg.push_back(8'h00);
		queue_message();
		// A bare LF at the start fails, and the error then holds.
		msg.delete();
		msg.push_back(hrhp_pkg::CH_LF);
		msg.push_back(8'h7F);
		queue_message();
		directed_beats = byte_stream.size();

		while (byte_stream.size() < directed_beats + RANDOM_BEATS) begin
			build_message();
			if ($urandom_range(3) == 0) begin
				damage_message();
			end
			queue_message();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (byte_stream[i]) begin
			calm = (i >= 250 && i < 400);
			send_beat(byte_stream[i]);
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("http_request_head_parser test passed");
		end else begin
			$display("http_request_head_parser test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hrhp_pkg.sv
rtl/hrhp_if.sv
rtl/hrhp_lexer.sv
rtl/http_request_head_parser.sv
sim/http_request_head_parser_lex_check.sv
sim/http_request_head_parser_tb.sv
